// ===== design/de_rham_ifs_point_generator_core_assert.svh =====
// Assertion macros used by the point generator core.
// Define ASSERT_OFF to compile the assertions out.
`ifndef DE_RHAM_IFS_POINT_GENERATOR_CORE_ASSERT_SVH
`define DE_RHAM_IFS_POINT_GENERATOR_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// Property must hold at every rising clock edge outside reset.
`define DRIFS_ASSERT(lbl, clock, reset, prop, msg) \
  lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Expression must never be true outside reset.
`define DRIFS_ASSERT_NEVER(lbl, clock, reset, expr, msg) \
  lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`else

`define DRIFS_ASSERT(lbl, clock, reset, prop, msg)
`define DRIFS_ASSERT_NEVER(lbl, clock, reset, expr, msg)

`endif

`endif

// ===== design/drifs_pkg.sv =====
package drifs_pkg;

  // Field widths.
  localparam int COEF_W    = 18;
  localparam int CSUM_W    = COEF_W + 1;
  localparam int COORD_W   = 20;
  localparam int REG_IDX_W = 3;

  // Parameter defaults.
  localparam int DEPTH_DEF     = 15;
  localparam int FRAC_BITS_DEF = 16;

  // Coordinate saturation limits.
  localparam int COORD_MAX = (1 << (COORD_W - 1)) - 1;
  localparam int COORD_MIN = -(1 << (COORD_W - 1));

  // Configuration register indexes.
  localparam logic [REG_IDX_W-1:0] REG_A_RE = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_A_IM = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_B_RE = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_B_IM = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_C_RE = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_C_IM = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_D_RE = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_D_IM = 3'd7;

  // Reset values of the coefficient registers.
  localparam logic signed [COEF_W-1:0] RST_A_RE = 18'sd30238;
  localparam logic signed [COEF_W-1:0] RST_A_IM = 18'sd30238;
  localparam logic signed [COEF_W-1:0] RST_B_RE = 18'sd0;
  localparam logic signed [COEF_W-1:0] RST_B_IM = 18'sd0;
  localparam logic signed [COEF_W-1:0] RST_C_RE = 18'sd40763;
  localparam logic signed [COEF_W-1:0] RST_C_IM = -18'sd12845;
  localparam logic signed [COEF_W-1:0] RST_D_RE = 18'sd0;
  localparam logic signed [COEF_W-1:0] RST_D_IM = 18'sd0;

  // Folded coefficients of one map, P*w + Q*conj(w):
  //   re = rr*wx + ri*wy,  im = ir*wx + ii*wy
  typedef struct packed {
    logic signed [CSUM_W-1:0] rr;
    logic signed [CSUM_W-1:0] ri;
    logic signed [CSUM_W-1:0] ir;
    logic signed [CSUM_W-1:0] ii;
  } coef_set_t;

  // Coefficients of both maps.
  typedef struct packed {
    coef_set_t f0;
    coef_set_t f1;
  } map_coef_t;

endpackage

// ===== design/de_rham_ifs_point_generator_core.sv =====
// Two-map de Rham curve point generator.
//
// Input channel: point_index with in_valid / in_stall. The index bits pick
// one map per level, most significant bit first, starting from z = 0.
// Output channel: point_x / point_y (signed Q4.16, saturated) with
// out_valid / out_stall. Configuration: cfg_valid / cfg_ready with
// cfg_index and cfg_data writes the eight Q2.16 coefficient registers;
// cfg_ready is always high. Write coefficients only while the block is idle.
//
// Pipeline: one input register, then two stages per level (multiply, then
// sum and saturate). One point can be taken every cycle unless a stalled
// output holds the pipeline.
//
// Reset clears all valid bits and loads the default coefficients.
// While a result sits on the output and out_stall is high, the whole
// pipeline holds and in_stall is raised; nothing is dropped or repeated.
module de_rham_ifs_point_generator_core
  import drifs_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [DEPTH-1:0]            point_index,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [COORD_W-1:0]   point_x,
  output logic signed [COORD_W-1:0]   point_y,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [REG_IDX_W-1:0]        cfg_index,
  input  logic signed [COEF_W-1:0]    cfg_data
);

`include "de_rham_ifs_point_generator_core_assert.svh"

  map_coef_t                 coef;
  logic                      en;
  logic                      s0_valid;
  logic [DEPTH-1:0]          s0_idx;
  logic [DEPTH:0]            lv;
  logic [DEPTH-1:0]          idx_pipe [DEPTH+1];
  logic signed [COORD_W-1:0] x_pipe   [DEPTH+1];
  logic signed [COORD_W-1:0] y_pipe   [DEPTH+1];

  // Coefficient registers.
  drifs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef)
  );

  // The pipeline moves whenever the output register is free or drained.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_idx <= point_index;
    end
  end

  assign lv[0]       = s0_valid;
  assign idx_pipe[0] = s0_idx;
  assign x_pipe[0]   = '0;
  assign y_pipe[0]   = '0;

  // One map level per index bit.
  for (genvar k = 0; k < DEPTH; k++) begin : g_level
    drifs_level #(
      .DEPTH     (DEPTH),
      .FRAC_BITS (FRAC_BITS)
    ) u_level (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .coef      (coef),
      .in_valid  (lv[k]),
      .in_idx    (idx_pipe[k]),
      .in_x      (x_pipe[k]),
      .in_y      (y_pipe[k]),
      .out_valid (lv[k+1]),
      .out_idx   (idx_pipe[k+1]),
      .out_x     (x_pipe[k+1]),
      .out_y     (y_pipe[k+1])
    );
  end

  assign out_valid = lv[DEPTH];
  assign point_x   = x_pipe[DEPTH];
  assign point_y   = y_pipe[DEPTH];

  // A stalled output freezes every valid bit in the pipeline.
  `DRIFS_ASSERT(a_stall_freezes, clk, rst, (out_valid && out_stall) |=> $stable(lv), "pipeline moved while output stalled")

  // A transfer in always lands in the input register.
  `DRIFS_ASSERT(a_accept_lands, clk, rst, (in_valid && !in_stall) |=> s0_valid, "accepted point was lost")

  // Every index bit has been consumed by the time a point leaves.
  `DRIFS_ASSERT_NEVER(a_idx_consumed, clk, rst, out_valid && (idx_pipe[DEPTH] != '0), "index bits left over at output")

endmodule

// ===== design/drifs_cfg.sv =====
module drifs_cfg
  import drifs_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [REG_IDX_W-1:0]        cfg_index,
  input  logic signed [COEF_W-1:0]    cfg_data,
  output map_coef_t                   coef
);

  logic signed [COEF_W-1:0] a_re, a_im, b_re, b_im;
  logic signed [COEF_W-1:0] c_re, c_im, d_re, d_im;
  map_coef_t                coef_next;

  // Writes are always taken.
  assign cfg_ready = 1'b1;

  // Coefficient register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_re <= RST_A_RE;
      a_im <= RST_A_IM;
      b_re <= RST_B_RE;
      b_im <= RST_B_IM;
      c_re <= RST_C_RE;
      c_im <= RST_C_IM;
      d_re <= RST_D_RE;
      d_im <= RST_D_IM;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_A_RE: a_re <= cfg_data;
        REG_A_IM: a_im <= cfg_data;
        REG_B_RE: b_re <= cfg_data;
        REG_B_IM: b_im <= cfg_data;
        REG_C_RE: c_re <= cfg_data;
        REG_C_IM: c_im <= cfg_data;
        REG_D_RE: d_re <= cfg_data;
        REG_D_IM: d_im <= cfg_data;
        default: ;
      endcase
    end
  end

  // Fold the conjugate term into the linear one, so that each output part
  // needs two products instead of four.
  always_comb begin
    coef_next.f0.rr = CSUM_W'(a_re) + CSUM_W'(b_re);
    coef_next.f0.ri = CSUM_W'(b_im) - CSUM_W'(a_im);
    coef_next.f0.ir = CSUM_W'(a_im) + CSUM_W'(b_im);
    coef_next.f0.ii = CSUM_W'(a_re) - CSUM_W'(b_re);
    coef_next.f1.rr = CSUM_W'(c_re) + CSUM_W'(d_re);
    coef_next.f1.ri = CSUM_W'(d_im) - CSUM_W'(c_im);
    coef_next.f1.ir = CSUM_W'(c_im) + CSUM_W'(d_im);
    coef_next.f1.ii = CSUM_W'(c_re) - CSUM_W'(d_re);
  end

  // Registered folded coefficients; a write passes the register file, then this register.
  always_ff @(posedge clk) begin
    coef <= coef_next;
  end

endmodule

// ===== design/drifs_level.sv =====
module drifs_level
  import drifs_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  map_coef_t                   coef,
  input  logic                        in_valid,
  input  logic [DEPTH-1:0]            in_idx,
  input  logic signed [COORD_W-1:0]   in_x,
  input  logic signed [COORD_W-1:0]   in_y,
  output logic                        out_valid,
  output logic [DEPTH-1:0]            out_idx,
  output logic signed [COORD_W-1:0]   out_x,
  output logic signed [COORD_W-1:0]   out_y
);

  // Operand width must hold x - 1.0 for any fraction width.
  localparam int WX_W   = ((FRAC_BITS + 1 > COORD_W) ? FRAC_BITS + 1 : COORD_W) + 1;
  localparam int PROD_W = CSUM_W + WX_W;
  localparam int SUM_W  = PROD_W + 1;

  localparam logic signed [WX_W-1:0]  ONE_WX  = WX_W'(1) << FRAC_BITS;
  localparam logic signed [WX_W-1:0]  ZERO_WX = '0;
  localparam logic signed [SUM_W-1:0] ONE_S   = SUM_W'(1) << FRAC_BITS;
  localparam logic signed [SUM_W-1:0] ZERO_S  = '0;
  localparam logic signed [SUM_W-1:0] MAX_S   = SUM_W'(COORD_MAX);
  localparam logic signed [SUM_W-1:0] MIN_S   = SUM_W'(COORD_MIN);

  logic                      sel;
  coef_set_t                 cs;
  logic signed [WX_W-1:0]    wx, wy;

  logic                      m_valid;
  logic [DEPTH-1:0]          m_idx;
  logic                      m_sel;
  logic signed [PROD_W-1:0]  p_rx, p_ry, p_ix, p_iy;

  logic signed [SUM_W-1:0]   s_r, s_i, t_r, t_i;
  logic signed [COORD_W-1:0] x_next, y_next;

  // The top index bit picks the map; f1 works on z - 1.
  assign sel = in_idx[DEPTH-1];
  assign cs  = sel ? coef.f1 : coef.f0;
  assign wx  = WX_W'(in_x) - (sel ? ONE_WX : ZERO_WX);
  assign wy  = WX_W'(in_y);

  // Multiply stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en) begin
      m_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_idx <= in_idx << 1;
      m_sel <= sel;
      p_rx  <= $signed(cs.rr) * wx;
      p_ry  <= $signed(cs.ri) * wy;
      p_ix  <= $signed(cs.ir) * wx;
      p_iy  <= $signed(cs.ii) * wy;
    end
  end

  // Sum, floor shift, undo the f1 offset and saturate.
  always_comb begin
    s_r = SUM_W'(p_rx) + SUM_W'(p_ry);
    s_i = SUM_W'(p_ix) + SUM_W'(p_iy);
    t_r = (s_r >>> FRAC_BITS) + (m_sel ? ONE_S : ZERO_S);
    t_i = s_i >>> FRAC_BITS;
    if (t_r > MAX_S) begin
      x_next = COORD_W'(COORD_MAX);
    end else if (t_r < MIN_S) begin
      x_next = COORD_W'(COORD_MIN);
    end else begin
      x_next = t_r[COORD_W-1:0];
    end
    if (t_i > MAX_S) begin
      y_next = COORD_W'(COORD_MAX);
    end else if (t_i < MIN_S) begin
      y_next = COORD_W'(COORD_MIN);
    end else begin
      y_next = t_i[COORD_W-1:0];
    end
  end

  // Sum stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_idx <= m_idx;
      out_x   <= x_next;
      out_y   <= y_next;
    end
  end

endmodule

// ===== sim/testbench.sv =====
module testbench;
  import drifs_pkg::*;

  localparam int LATENCY     = 2 * DEPTH_DEF + 1;
  localparam int CYCLE_LIMIT = 250000;
  localparam logic signed [COEF_W-1:0] COEF_MAX = COEF_W'((1 << (COEF_W - 1)) - 1);
  localparam logic signed [COEF_W-1:0] COEF_MIN = COEF_W'(-(1 << (COEF_W - 1)));
  localparam logic signed [COEF_W-1:0] COEF_ZERO = '0;
  localparam logic [DEPTH_DEF-1:0]     INDEX_MAX = '1;
  localparam logic [DEPTH_DEF-1:0]     INDEX_ONE = DEPTH_DEF'(1);

  typedef struct {
    logic [DEPTH_DEF-1:0]      idx;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } point_t;

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        in_valid;
  logic                        in_stall;
  logic [DEPTH_DEF-1:0]        point_index;
  logic                        out_valid;
  logic                        out_stall;
  logic signed [COORD_W-1:0]   point_x;
  logic signed [COORD_W-1:0]   point_y;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [REG_IDX_W-1:0]        cfg_index;
  logic signed [COEF_W-1:0]    cfg_data;

  // Local copy of the coefficient registers and the points still to come out.
  logic signed [COEF_W-1:0] coef_reg [8];
  point_t                   pending_points [$];

  int errors      = 0;
  int cycle_count = 0;
  int max_gap     = 12;
  int max_stall   = 12;
  int hold_req    = 0;

  de_rham_ifs_point_generator_core dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .point_index (point_index),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .point_x     (point_x),
    .point_y     (point_y),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #10 clk = ~clk;

  // Clamp a coordinate to the signed 20-bit range.
  function automatic longint clamp_coord(input longint v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  // Walk the index bits from the top and apply one map per level.
  function automatic point_t predict_point(input logic [DEPTH_DEF-1:0] idx);
    longint one, x, y, wx, pr, pi, qr, qi, off, sr, si;
    point_t p;
    one = longint'(1) <<< FRAC_BITS_DEF;
    x = 0;
    y = 0;
    for (int lvl = DEPTH_DEF - 1; lvl >= 0; lvl--) begin
      if (idx[lvl]) begin
        pr  = longint'(coef_reg[REG_C_RE]);
        pi  = longint'(coef_reg[REG_C_IM]);
        qr  = longint'(coef_reg[REG_D_RE]);
        qi  = longint'(coef_reg[REG_D_IM]);
        off = one;
      end else begin
        pr  = longint'(coef_reg[REG_A_RE]);
        pi  = longint'(coef_reg[REG_A_IM]);
        qr  = longint'(coef_reg[REG_B_RE]);
        qi  = longint'(coef_reg[REG_B_IM]);
        off = 0;
      end
      wx = x - off;
      sr = pr * wx - pi * y + qr * wx + qi * y;
      si = pi * wx + pr * y + qi * wx - qr * y;
      x = clamp_coord((sr >>> FRAC_BITS_DEF) + off);
      y = clamp_coord(si >>> FRAC_BITS_DEF);
    end
    p.idx = idx;
    p.x   = x[COORD_W-1:0];
    p.y   = y[COORD_W-1:0];
    return p;
  endfunction

  // Coefficient draw: extremes, anything, or a contracting value.
  function automatic logic signed [COEF_W-1:0] draw_coef();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
      1:       return COEF_W'($urandom);
      default: return COEF_W'(int'($urandom_range(0, 80000)) - 40000);
    endcase
  endfunction

  // Index draw: dense, sparse single bits, near the two extremes.
  function automatic logic [DEPTH_DEF-1:0] draw_index();
    logic [DEPTH_DEF-1:0] one_hot;
    one_hot = INDEX_ONE << $urandom_range(0, DEPTH_DEF - 1);
    case ($urandom_range(0, 4))
      0:       return one_hot;
      1:       return ~one_hot;
      2:       return $urandom_range(0, 1) ? INDEX_MAX : '0;
      default: return DEPTH_DEF'($urandom_range(0, INDEX_MAX));
    endcase
  endfunction

  // Send one point index and record the point it should produce.
  task automatic send_point(input logic [DEPTH_DEF-1:0] idx);
    int gap;
    point_t p;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    point_index <= idx;
    do @(posedge clk); while (in_stall);
    p = predict_point(idx);
    pending_points.insert(pending_points.size(), p);
  endtask

  // Stop sending and wait until every pending point has come out.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_points.size() != 0);
  endtask

  // One register transfer; the caller lowers cfg_valid after the last one.
  task automatic write_coef(input logic [REG_IDX_W-1:0] idx,
                            input logic signed [COEF_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    coef_reg[idx] = val;
  endtask

  task automatic set_coefs(input logic signed [COEF_W-1:0] ar, ai, br, bi,
                           input logic signed [COEF_W-1:0] cr, ci, dr, di);
    wait_idle();
    write_coef(REG_A_RE, ar);
    write_coef(REG_A_IM, ai);
    write_coef(REG_B_RE, br);
    write_coef(REG_B_IM, bi);
    write_coef(REG_C_RE, cr);
    write_coef(REG_C_IM, ci);
    write_coef(REG_D_RE, dr);
    write_coef(REG_D_IM, di);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_random_coefs();
    set_coefs(draw_coef(), draw_coef(), draw_coef(), draw_coef(),
              draw_coef(), draw_coef(), draw_coef(), draw_coef());
  endtask

  // Default coefficients: both maps alone, all-zero and all-one indexes,
  // alternating patterns and single bits.
  task automatic test_reset_coefficients();
    send_point('0);
    send_point(INDEX_MAX);
    send_point(INDEX_ONE);
    send_point(INDEX_ONE << (DEPTH_DEF - 1));
    send_point(INDEX_MAX >> 1);
    send_point(INDEX_MAX - INDEX_ONE);
    send_point(DEPTH_DEF'({(DEPTH_DEF + 1) / 2{2'b01}}));
    send_point(DEPTH_DEF'({(DEPTH_DEF + 1) / 2{2'b10}}));
    send_point(15'h0F0F);
    send_point(15'h70F0);
  endtask

  // Coefficients at their limits, so coordinates saturate at inner levels, then all zero.
  task automatic test_extreme_coefficients();
    set_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX,
              COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
    send_point('0);
    send_point(INDEX_MAX);
    send_point(INDEX_ONE << (DEPTH_DEF - 1));
    send_point(15'h7F00);
    send_point(15'h5555);
    set_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN,
              COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
    send_point(INDEX_MAX);
    send_point(INDEX_ONE << (DEPTH_DEF - 1));
    send_point(15'h6000);
    send_point(15'h2AAA);
    set_coefs(COEF_MAX, COEF_MIN, COEF_MIN, COEF_MAX,
              COEF_MIN, COEF_MAX, COEF_MAX, COEF_MIN);
    send_point(INDEX_MAX);
    send_point(15'h4001);
    set_coefs(COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO,
              COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO);
    send_point(INDEX_MAX);
    send_point(15'h3FFE);
  endtask

  // Several random coefficient sets, each with a stream of random indexes.
  task automatic test_random_coefficients();
    for (int phase = 0; phase < 7; phase++) begin
      set_random_coefs();
      for (int i = 0; i < 160; i++) send_point(draw_index());
    end
  endtask

  // Receiver holds off long enough for the pipeline to fill and stall input,
  // then the sender pauses until everything has drained and sends 30 more points.
  task automatic test_backpressure();
    set_random_coefs();
    max_gap  = 0;
    hold_req = 300;
    for (int i = 0; i < 80; i++) send_point(draw_index());
    max_gap = 12;
    wait_idle();
    for (int i = 0; i < 30; i++) send_point(draw_index());
  endtask

  // Full-rate stretch on the default coefficients with neither side idling.
  task automatic test_full_rate();
    set_coefs(RST_A_RE, RST_A_IM, RST_B_RE, RST_B_IM,
              RST_C_RE, RST_C_IM, RST_D_RE, RST_D_IM);
    max_gap   = 0;
    max_stall = 0;
    for (int i = 0; i < 100; i++) send_point(draw_index());
    wait_idle();
    max_gap   = 12;
    max_stall = 12;
  endtask

  // Receiver: random stall before each transfer, or a long hold on request.
  initial begin
    int n;
    out_stall = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
      end else begin
        n = $urandom_range(0, max_stall);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid && hold_req == 0);
    end
  end

  // Compare each output transfer with the oldest pending point.
  always @(posedge clk) begin : check_points
    point_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_points.size() == 0) begin
        $display("%0t: expected no point, got x=%0d y=%0d", $time, point_x, point_y);
        errors++;
      end else begin
        want = pending_points.pop_front();
        if (point_x !== want.x) begin
          $display("%0t: index %h point_x expected %0d got %0d",
                   $time, want.idx, want.x, point_x);
          errors++;
        end
        if (point_y !== want.y) begin
          $display("%0t: index %h point_y expected %0d got %0d",
                   $time, want.idx, want.y, point_y);
          errors++;
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    point_index = '0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_A_RE;
    cfg_data    = '0;
    coef_reg[REG_A_RE] = RST_A_RE;
    coef_reg[REG_A_IM] = RST_A_IM;
    coef_reg[REG_B_RE] = RST_B_RE;
    coef_reg[REG_B_IM] = RST_B_IM;
    coef_reg[REG_C_RE] = RST_C_RE;
    coef_reg[REG_C_IM] = RST_C_IM;
    coef_reg[REG_D_RE] = RST_D_RE;
    coef_reg[REG_D_IM] = RST_D_IM;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_reset_coefficients();
    test_extreme_coefficients();
    test_random_coefficients();
    test_backpressure();
    test_full_rate();

    // Drain, then give any stray output time to show up.
    wait_idle();
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
